>>> rtl/cbs_pkg.sv
`default_nettype none

package cbs_pkg;

   // controller states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SPLIT_A = 5'b00010,
      ST_SPLIT_B = 5'b00100,
      ST_SPLIT_C = 5'b01000,
      ST_EMIT    = 5'b10000
   } cbs_state_type;

   // width of the depth field on the request channel
   localparam int unsigned DEPTH_BITS = 3;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;     // take the four control points of a new curve
      logic split_a;  // first midpoints of the control polygon
      logic split_b;  // second midpoints
      logic split_c;  // split point, push right half, keep left half
      logic emit;     // load the output register with the current chord
      logic pop;      // restore a pending right half from the stack
      logic last;     // flag for the chord being emitted
   } cbs_cmd_type;

endpackage

`default_nettype wire

>>> rtl/cbs_if.sv
`default_nettype none

interface cbs_req_if
   import cbs_pkg::*;
#(
   parameter int unsigned COORD_BITS = 16
);

   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] pull1_x;
   logic signed [COORD_BITS-1:0] pull1_y;
   logic signed [COORD_BITS-1:0] pull2_x;
   logic signed [COORD_BITS-1:0] pull2_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic [DEPTH_BITS-1:0]        depth;

   modport source (
      output valid, start_x, start_y, pull1_x, pull1_y, pull2_x, pull2_y,
             end_x, end_y, depth,
      input  ready
   );

   modport sink (
      input  valid, start_x, start_y, pull1_x, pull1_y, pull2_x, pull2_y,
             end_x, end_y, depth,
      output ready
   );
endinterface

interface cbs_rsp_if #(
   parameter int unsigned COORD_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] seg_x0;
   logic signed [COORD_BITS-1:0] seg_y0;
   logic signed [COORD_BITS-1:0] seg_x1;
   logic signed [COORD_BITS-1:0] seg_y1;
   logic                         last_segment;

   modport source (
      output valid, seg_x0, seg_y0, seg_x1, seg_y1, last_segment,
      input  ready
   );

   modport sink (
      input  valid, seg_x0, seg_y0, seg_x1, seg_y1, last_segment,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/cbs_dpath.sv
`default_nettype none

module cbs_dpath
   import cbs_pkg::*;
#(
   parameter int unsigned MAX_DEPTH  = 6,
   parameter int unsigned COORD_BITS = 16,
   parameter int unsigned IDX_BITS   = 3
) (
   input  wire logic                         clock,
   input  wire cbs_cmd_type                  cmd,
   input  wire logic [IDX_BITS-1:0]          stk_idx,
   input  wire logic signed [COORD_BITS-1:0] in_x [4],
   input  wire logic signed [COORD_BITS-1:0] in_y [4],
   output logic signed [COORD_BITS-1:0]      seg_x0,
   output logic signed [COORD_BITS-1:0]      seg_y0,
   output logic signed [COORD_BITS-1:0]      seg_x1,
   output logic signed [COORD_BITS-1:0]      seg_y1,
   output logic                              last_segment
);

   // three fraction bits per level keep every midpoint exact
   localparam int unsigned FRAC = 3 * MAX_DEPTH;
   localparam int unsigned FW   = COORD_BITS + FRAC;

   logic signed [FW-1:0] px_ff [4];
   logic signed [FW-1:0] py_ff [4];
   logic signed [FW-1:0] tx_ff [3];
   logic signed [FW-1:0] ty_ff [3];
   logic signed [FW-1:0] abx_ff, aby_ff, bcx_ff, bcy_ff;
   logic signed [FW-1:0] midx, midy;
   logic signed [FW-1:0] sx_ff [MAX_DEPTH][4];
   logic signed [FW-1:0] sy_ff [MAX_DEPTH][4];
   logic signed [COORD_BITS-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic                         last_ff;

   function automatic logic signed [FW-1:0] widen(input logic signed [COORD_BITS-1:0] c);
      return {c, {FRAC{1'b0}}};
   endfunction

   // exact halving: the sum is always even at this precision
   function automatic logic signed [FW-1:0] half(input logic signed [FW-1:0] a,
                                                 input logic signed [FW-1:0] b);
      logic signed [FW:0] s;
      s = {a[FW-1], a} + {b[FW-1], b};
      return s[FW:1];
   endfunction

   // integer part, truncated toward zero
   function automatic logic signed [COORD_BITS-1:0] narrow(input logic signed [FW-1:0] v);
      logic signed [COORD_BITS-1:0] q;
      q = v[FW-1:FRAC];
      if (v[FW-1] && (v[FRAC-1:0] != '0)) begin
         q = q + COORD_BITS'(1);
      end
      return q;
   endfunction

   assign midx = half(abx_ff, bcx_ff);
   assign midy = half(aby_ff, bcy_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 4; i++) begin
            px_ff[i] <= widen(in_x[i]);
            py_ff[i] <= widen(in_y[i]);
         end
      end
      if (cmd.split_a) begin
         for (int i = 0; i < 3; i++) begin
            tx_ff[i] <= half(px_ff[i], px_ff[i+1]);
            ty_ff[i] <= half(py_ff[i], py_ff[i+1]);
         end
      end
      if (cmd.split_b) begin
         abx_ff <= half(tx_ff[0], tx_ff[1]);
         aby_ff <= half(ty_ff[0], ty_ff[1]);
         bcx_ff <= half(tx_ff[1], tx_ff[2]);
         bcy_ff <= half(ty_ff[1], ty_ff[2]);
      end
      if (cmd.split_c) begin
         // right half waits on the stack, left half goes on
         sx_ff[stk_idx][0] <= midx;
         sy_ff[stk_idx][0] <= midy;
         sx_ff[stk_idx][1] <= bcx_ff;
         sy_ff[stk_idx][1] <= bcy_ff;
         sx_ff[stk_idx][2] <= tx_ff[2];
         sy_ff[stk_idx][2] <= ty_ff[2];
         sx_ff[stk_idx][3] <= px_ff[3];
         sy_ff[stk_idx][3] <= py_ff[3];
         px_ff[1] <= tx_ff[0];
         py_ff[1] <= ty_ff[0];
         px_ff[2] <= abx_ff;
         py_ff[2] <= aby_ff;
         px_ff[3] <= midx;
         py_ff[3] <= midy;
      end
      if (cmd.emit) begin
         x0_ff   <= narrow(px_ff[0]);
         y0_ff   <= narrow(py_ff[0]);
         x1_ff   <= narrow(px_ff[3]);
         y1_ff   <= narrow(py_ff[3]);
         last_ff <= cmd.last;
      end
      if (cmd.pop) begin
         for (int i = 0; i < 4; i++) begin
            px_ff[i] <= sx_ff[stk_idx][i];
            py_ff[i] <= sy_ff[stk_idx][i];
         end
      end
   end

   assign seg_x0       = x0_ff;
   assign seg_y0       = y0_ff;
   assign seg_x1       = x1_ff;
   assign seg_y1       = y1_ff;
   assign last_segment = last_ff;

endmodule

`default_nettype wire

>>> rtl/cbs_ctrl.sv
`default_nettype none

module cbs_ctrl
   import cbs_pkg::*;
#(
   parameter int unsigned MAX_DEPTH = 6,
   parameter int unsigned LVL_BITS  = 3,
   parameter int unsigned IDX_BITS  = 3
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [DEPTH_BITS-1:0] req_depth,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output cbs_cmd_type                cmd,
   output logic [IDX_BITS-1:0]        stk_idx
);

   cbs_state_type       state_ff, state_in;
   logic [LVL_BITS-1:0] level_ff, level_in;
   logic [LVL_BITS-1:0] top_ff, top_in;
   logic [LVL_BITS-1:0] target_ff, target_in;
   logic [LVL_BITS-1:0] lv_ff [MAX_DEPTH];
   logic                rsp_valid_ff, rsp_valid_in;
   logic                req_fire, slot_free;
   logic [LVL_BITS-1:0] top_dec, level_inc, pop_level;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign top_dec   = top_ff - LVL_BITS'(1);
   assign level_inc = level_ff + LVL_BITS'(1);
   assign pop_level = lv_ff[top_dec[IDX_BITS-1:0]];

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      top_in       = top_ff;
      target_in    = target_ff;
      cmd          = '0;
      stk_idx      = top_ff[IDX_BITS-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               level_in = '0;
               top_in   = '0;
               // depth saturates at the deepest level
               if (req_depth > DEPTH_BITS'(MAX_DEPTH)) begin
                  target_in = LVL_BITS'(MAX_DEPTH);
               end else begin
                  target_in = LVL_BITS'(req_depth);
               end
               state_in = (target_in != '0) ? ST_SPLIT_A : ST_EMIT;
            end
         end
         ST_SPLIT_A: begin
            cmd.split_a = 1'b1;
            state_in    = ST_SPLIT_B;
         end
         ST_SPLIT_B: begin
            cmd.split_b = 1'b1;
            state_in    = ST_SPLIT_C;
         end
         ST_SPLIT_C: begin
            cmd.split_c = 1'b1;
            level_in    = level_inc;
            top_in      = top_ff + LVL_BITS'(1);
            state_in    = (level_inc < target_ff) ? ST_SPLIT_A : ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               cmd.emit     = 1'b1;
               cmd.last     = (top_ff == '0);
               rsp_valid_in = 1'b1;
               if (top_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.pop  = 1'b1;
                  stk_idx  = top_dec[IDX_BITS-1:0];
                  top_in   = top_dec;
                  level_in = pop_level;
                  state_in = (pop_level < target_ff) ? ST_SPLIT_A : ST_EMIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         top_ff       <= '0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         top_ff       <= top_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // level of each pending right half
   always_ff @(posedge clock) begin
      if (cmd.split_c) begin
         lv_ff[top_ff[IDX_BITS-1:0]] <= level_inc;
      end
   end

   // pending halves never outnumber the levels descended
   assert property (@(posedge clock) disable iff (reset) top_ff <= level_ff)
      else $error("stack deeper than current level");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPLIT_A) |-> (level_ff < target_ff))
      else $error("split started at target depth");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> (state_ff == ST_IDLE))
      else $error("curve did not finish after last segment");

   assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (cmd.emit && !cmd.last))
      else $error("stack popped without a segment");

endmodule

`default_nettype wire

>>> rtl/cubic_bezier_subdivider_top.sv
// channel  role     modport        payload
// req_chan curve    cbs_req_if.sink  four control points (x, y), depth
// rsp_chan segment  cbs_rsp_if.source chord ends (x0, y0, x1, y1), last_segment
//
// a curve of depth d is worked as one load, then ST_SPLIT_A, ST_SPLIT_B and ST_SPLIT_C for each
// of its 2^d - 1 splits, and one emit for each of its 2^d segments
// one curve is worked at a time; req_chan.ready is high only between curves,
// and the next curve is taken while the last segment still waits in the output register
// reset is synchronous, active high, and clears the controller and rsp_chan.valid
// a stall on rsp_chan holds the controller in its emit state
`default_nettype none

module cubic_bezier_subdivider_top
   import cbs_pkg::*;
#(
   parameter int unsigned MAX_DEPTH  = 6,
   parameter int unsigned COORD_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   cbs_req_if.sink   req_chan,
   cbs_rsp_if.source rsp_chan
);

   localparam int unsigned LVL_BITS = $clog2(MAX_DEPTH + 1);
   localparam int unsigned IDX_BITS = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   cbs_cmd_type                  cmd;
   logic [IDX_BITS-1:0]          stk_idx;
   logic signed [COORD_BITS-1:0] in_x [4];
   logic signed [COORD_BITS-1:0] in_y [4];

   assign in_x[0] = req_chan.start_x;
   assign in_y[0] = req_chan.start_y;
   assign in_x[1] = req_chan.pull1_x;
   assign in_y[1] = req_chan.pull1_y;
   assign in_x[2] = req_chan.pull2_x;
   assign in_y[2] = req_chan.pull2_y;
   assign in_x[3] = req_chan.end_x;
   assign in_y[3] = req_chan.end_y;

   cbs_ctrl #(
      .MAX_DEPTH (MAX_DEPTH),
      .LVL_BITS  (LVL_BITS),
      .IDX_BITS  (IDX_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_depth (req_chan.depth),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stk_idx   (stk_idx)
   );

   cbs_dpath #(
      .MAX_DEPTH  (MAX_DEPTH),
      .COORD_BITS (COORD_BITS),
      .IDX_BITS   (IDX_BITS)
   ) u_dpath (
      .clock        (clock),
      .cmd          (cmd),
      .stk_idx      (stk_idx),
      .in_x         (in_x),
      .in_y         (in_y),
      .seg_x0       (rsp_chan.seg_x0),
      .seg_y0       (rsp_chan.seg_y0),
      .seg_x1       (rsp_chan.seg_x1),
      .seg_y1       (rsp_chan.seg_y1),
      .last_segment (rsp_chan.last_segment)
   );

endmodule

`default_nettype wire

>>> test/segment_checker.sv
module segment_checker
   import cbs_pkg::*;
#(
   parameter int unsigned MAX_DEPTH  = 6,
   parameter int unsigned COORD_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   cbs_req_if   req_mon,
   cbs_rsp_if   rsp_mon,
   output int   errors,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // three fraction bits per halving level keep every midpoint exact
   localparam int     FRAC_BITS = 3 * MAX_DEPTH;
   localparam longint ONE_PIXEL = longint'(1) << FRAC_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct {
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
      logic      last;
   } segment_type;

   segment_type segments_due[$];

   task automatic report_mismatch(input string msg);
      errors++;
      $display("%0t: %s", $realtime, msg);
   endtask

   function automatic longint midpoint(input longint a, input longint b);
      // signed division truncates toward zero
      return (a + b) / 2;
   endfunction

   function automatic coord_type to_pixel(input longint v);
      longint whole;
      whole = v / ONE_PIXEL;
      return whole[COORD_BITS-1:0];
   endfunction

   // splits the curve on req_mon depth first and queues one chord per piece
   task automatic subdivide_curve();
      longint      pt[4][2];
      longint      stk[MAX_DEPTH][4][2];
      int          stk_lvl[MAX_DEPTH];
      longint      a, b, c, ab, bc, mid;
      int          top_n, lvl, tgt;
      bit          done;
      segment_type seg;
      tgt = (req_mon.depth > MAX_DEPTH) ? MAX_DEPTH : req_mon.depth;
      pt[0][0] = longint'(req_mon.start_x) * ONE_PIXEL;
      pt[0][1] = longint'(req_mon.start_y) * ONE_PIXEL;
      pt[1][0] = longint'(req_mon.pull1_x) * ONE_PIXEL;
      pt[1][1] = longint'(req_mon.pull1_y) * ONE_PIXEL;
      pt[2][0] = longint'(req_mon.pull2_x) * ONE_PIXEL;
      pt[2][1] = longint'(req_mon.pull2_y) * ONE_PIXEL;
      pt[3][0] = longint'(req_mon.end_x) * ONE_PIXEL;
      pt[3][1] = longint'(req_mon.end_y) * ONE_PIXEL;
      top_n = 0;
      lvl = 0;
      done = 1'b0;
      while (!done) begin
         while (lvl < tgt && top_n < MAX_DEPTH) begin
            for (int k = 0; k < 2; k++) begin
               a   = midpoint(pt[0][k], pt[1][k]);
               b   = midpoint(pt[1][k], pt[2][k]);
               c   = midpoint(pt[2][k], pt[3][k]);
               ab  = midpoint(a, b);
               bc  = midpoint(b, c);
               mid = midpoint(ab, bc);
               // right half waits on the stack, left half goes on
               stk[top_n][0][k] = mid;
               stk[top_n][1][k] = bc;
               stk[top_n][2][k] = c;
               stk[top_n][3][k] = pt[3][k];
               pt[1][k] = a;
               pt[2][k] = ab;
               pt[3][k] = mid;
            end
            stk_lvl[top_n] = lvl + 1;
            top_n++;
            lvl++;
         end
         seg.x0   = to_pixel(pt[0][0]);
         seg.y0   = to_pixel(pt[0][1]);
         seg.x1   = to_pixel(pt[3][0]);
         seg.y1   = to_pixel(pt[3][1]);
         seg.last = (top_n == 0);
         segments_due.push_back(seg);
         if (top_n == 0) begin
            done = 1'b1;
         end else begin
            top_n--;
            for (int j = 0; j < 4; j++) begin
               for (int k = 0; k < 2; k++) begin
                  pt[j][k] = stk[top_n][j][k];
               end
            end
            lvl = stk_lvl[top_n];
         end
      end
   endtask

   always @(posedge clock) begin : watch
      segment_type want;
      if (reset) begin
         segments_due.delete();
      end else begin
         // results first: the next curve may be taken on the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (segments_due.size() == 0) begin
               report_mismatch("segment transfer with no curve pending");
            end else begin
               want = segments_due.pop_front();
               if (rsp_mon.seg_x0 !== want.x0)
                  report_mismatch($sformatf("seg_x0 got %0d expected %0d",
                                            rsp_mon.seg_x0, want.x0));
               if (rsp_mon.seg_y0 !== want.y0)
                  report_mismatch($sformatf("seg_y0 got %0d expected %0d",
                                            rsp_mon.seg_y0, want.y0));
               if (rsp_mon.seg_x1 !== want.x1)
                  report_mismatch($sformatf("seg_x1 got %0d expected %0d",
                                            rsp_mon.seg_x1, want.x1));
               if (rsp_mon.seg_y1 !== want.y1)
                  report_mismatch($sformatf("seg_y1 got %0d expected %0d",
                                            rsp_mon.seg_y1, want.y1));
               if (rsp_mon.last_segment !== want.last)
                  report_mismatch($sformatf("last_segment got %b expected %b",
                                            rsp_mon.last_segment, want.last));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            subdivide_curve();
         end
      end
      outstanding <= segments_due.size();
   end

endmodule

>>> test/testbench.sv
module testbench
   import cbs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_DEPTH  = 6;
   localparam int unsigned COORD_BITS = 16;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic clock;
   logic reset;
   bit   calm;
   int   errors;
   int   outstanding;

   cbs_req_if #(.COORD_BITS(COORD_BITS)) req_chan();
   cbs_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_chan();

   cubic_bezier_subdivider_top #(
      .MAX_DEPTH (MAX_DEPTH),
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   segment_checker #(
      .MAX_DEPTH (MAX_DEPTH),
      .COORD_BITS(COORD_BITS)
   ) watcher (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .errors     (errors),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   function automatic coord_type pick_coord();
      int v;
      v = $urandom_range(0, 16);
      case ($urandom_range(0, 5))
         0: return coord_type'(v - 8);
         1: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         2: return $urandom_range(0, 1) ? COORD_MAX - coord_type'(v)
                                        : COORD_MIN + coord_type'(v);
         default: return coord_type'($urandom);
      endcase
   endfunction

   // mostly shallow curves, some at depth 5, at full depth or saturating
   function automatic logic [DEPTH_BITS-1:0] pick_depth();
      if ($urandom_range(0, 3) == 0) begin
         return DEPTH_BITS'($urandom_range(5, 7));
      end
      return DEPTH_BITS'($urandom_range(0, 4));
   endfunction

   task automatic send_curve(input coord_type sx, input coord_type sy, input coord_type ax,
                             input coord_type ay, input coord_type bx, input coord_type by,
                             input coord_type ex, input coord_type ey,
                             input logic [DEPTH_BITS-1:0] d);
      req_chan.valid   <= 1'b1;
      req_chan.start_x <= sx;
      req_chan.start_y <= sy;
      req_chan.pull1_x <= ax;
      req_chan.pull1_y <= ay;
      req_chan.pull2_x <= bx;
      req_chan.pull2_y <= by;
      req_chan.end_x   <= ex;
      req_chan.end_y   <= ey;
      req_chan.depth   <= d;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // segment side: random stall bursts, with long open stretches now and then
   initial begin
      rsp_chan.ready <= 1'b0;
      repeat (5) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(0, 7) == 0 ? $urandom_range(40, 200)
                                           : $urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.start_x <= '0;
      req_chan.start_y <= '0;
      req_chan.pull1_x <= '0;
      req_chan.pull1_y <= '0;
      req_chan.pull2_x <= '0;
      req_chan.pull2_y <= '0;
      req_chan.end_x   <= '0;
      req_chan.end_y   <= '0;
      req_chan.depth   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // single chord, no split
      send_curve(0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_curve(0, 0, 10, 20, 30, 20, 40, 0, 0);
      // small negative coordinates: fractions truncate toward zero
      send_curve(-7, 3, -20, 40, 25, -40, 5, -3, 1);
      send_curve(-7, 3, -20, 40, 25, -40, 5, -3, 2);
      send_curve(-7, 3, -20, 40, 25, -40, 5, -3, 3);
      send_curve(-1, -1, -3, 2, 1, -3, -2, 1, 6);
      send_curve(1, -1, 0, 3, -3, 0, 2, -2, 4);
      // full-range control polygons
      send_curve(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                 COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 4);
      send_curve(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                 COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, 5);
      send_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                 COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 6);
      send_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                 COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 3);
      send_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                 COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 2);
      // depth request above the maximum saturates
      send_curve(-5, 9, 13, -11, -17, 19, 23, -29, 7);
      send_curve(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                 COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 7);

      for (int i = 0; i < 120; i++) begin
         calm = (i >= 100);
         send_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    pick_depth());
      end
      req_chan.valid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (30) @(posedge clock);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
